// ----- rtl/core/bhl_pkg.sv -----
// Shared types and constants of the blocked-to-HWCN address generator.
// No dependencies; every other file of the block but bhl_div imports this package.
package bhl_pkg;

   // Default structural parameters
   localparam int DEF_DIM_BITS = 12;
   localparam int DEF_MAX_CUBE = 32;

   // Field widths fixed by the interface
   localparam int SRC_W      = 56;
   localparam int DST_W      = 50;
   localparam int HALF_W     = SRC_W / 2;
   localparam int CUBE_REG_W = 6;
   localparam int ELEM_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Register reset values
   localparam logic [CUBE_REG_W-1:0] CUBE_RESET = 6'd16;
   localparam logic [ELEM_W-1:0]     ELEM_RESET = 3'd2;

   // Command queue between front and back (depth is a power of two)
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIM_H      = 3'd0,
      CSR_DIM_W      = 3'd1,
      CSR_DIM_C      = 3'd2,
      CSR_DIM_N      = 3'd3,
      CSR_BLK_SIZE   = 3'd4,
      CSR_ELEM_BYTES = 3'd5
   } csr_idx_type;

   // Classified request
   typedef enum logic {
      CMD_NEXT    = 1'b0,
      CMD_RESTART = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      logic         valid;
      cmd_kind_type kind;
   } cmd_type;

   // Back-end sequencer
   typedef enum logic [2:0] {
      ST_IDLE = 3'd0,
      ST_DIV  = 3'd1,
      ST_PREP = 3'd2,
      ST_MUL  = 3'd3,
      ST_ADD  = 3'd4,
      ST_DONE = 3'd5
   } seq_state_type;

   // Horner steps of the offset evaluation
   typedef enum logic [2:0] {
      STEP_H     = 3'd0,
      STEP_W     = 3'd1,
      STEP_N     = 3'd2,
      STEP_CUBE  = 3'd3,
      STEP_SCALE = 3'd4
   } step_type;

   // Multiply-add lane control
   typedef struct packed {
      logic load;
      logic mul;
      logic add;
   } mac_ctl_type;

endpackage

// ----- rtl/core/bhl_ifs.sv -----
// Channel interfaces of the address generator: request, response, register write.
// Depends on bhl_pkg for the payload widths.
interface bhl_req_if ();
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface bhl_rsp_if import bhl_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SRC_W-1:0] src_byte_offset;
   logic [DST_W-1:0] dst_byte_offset;
   logic             last;

   modport source (output valid, output src_byte_offset, output dst_byte_offset,
                   output last, input ready);
   modport sink   (input valid, input src_byte_offset, input dst_byte_offset,
                   input last, output ready);
endinterface

interface bhl_csr_if import bhl_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ----- rtl/core/bhl_front.sv -----
// Front end: accepts request transactions, classifies them and queues them.
// Depends on bhl_pkg and bhl_req_if.
module bhl_front import bhl_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   bhl_req_if.sink   req_ch,
   output cmd_type   cmd,
   input  logic      cmd_pop
);

   cmd_kind_type       q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  q_count_ff, q_count_in;
   logic               push;
   logic               pop_ok;
   cmd_kind_type       kind_in;

   // Handshake and classification
   assign req_ch.ready = (q_count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push         = req_ch.valid && req_ch.ready;
   assign kind_in      = req_ch.restart ? CMD_RESTART : CMD_NEXT;
   assign pop_ok       = cmd_pop && cmd.valid;

   assign cmd.valid = (q_count_ff != '0);
   assign cmd.kind  = q_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in  = push   ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in  = pop_ok ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      q_count_in = q_count_ff;
      if (push && !pop_ok) begin
         q_count_in = q_count_ff + QCNT_W'(1);
      end else if (!push && pop_ok) begin
         q_count_in = q_count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         q_count_ff <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         q_count_ff <= q_count_in;
      end
   end

   // Queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= kind_in;
      end
   end

   // Checks
   a_q_bound: assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("command queue overfilled");

   a_q_push: assert property (@(posedge clock) disable iff (reset)
      (push && !pop_ok) |=> (q_count_ff == $past(q_count_ff) + QCNT_W'(1)))
      else $error("queued transaction not counted");

   a_q_pop: assert property (@(posedge clock) disable iff (reset)
      (pop_ok && !push) |=> (q_count_ff == $past(q_count_ff) - QCNT_W'(1)))
      else $error("popped transaction not removed");

endmodule

// ----- rtl/core/bhl_div.sv -----
// Restoring divider: splits the channel counter into cube index and offset,
// one quotient bit per cycle. Depends on nothing but its parameters.
module bhl_div #(
   parameter int DIM_BITS  = 12,
   parameter int CUBE_BITS = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIM_BITS-1:0]  dividend,
   input  logic [CUBE_BITS-1:0] divisor,
   output logic                 busy,
   output logic [DIM_BITS-1:0]  quotient,
   output logic [CUBE_BITS-1:0] remainder
);

   localparam int CNT_W = $clog2(DIM_BITS + 1);

   logic [DIM_BITS-1:0]  quo_ff, quo_in;
   logic [CUBE_BITS-1:0] rem_ff, rem_in;
   logic [CUBE_BITS-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [CUBE_BITS:0]   r_sh;
   logic [CUBE_BITS:0]   diff;
   logic                 ge;

   // One trial subtraction per cycle
   assign r_sh = {rem_ff, quo_ff[DIM_BITS-1]};
   assign ge   = (r_sh >= {1'b0, dvs_ff});
   assign diff = r_sh - {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DIM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIM_BITS-2:0], ge};
         rem_in = ge ? diff[CUBE_BITS-1:0] : r_sh[CUBE_BITS-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- rtl/core/bhl_mac.sv -----
// Multiply-add lane: acc = acc * b + addend modulo 2^SRC_W, as two half-width
// partial products in one cycle and their sum in the next. Depends on bhl_pkg.
module bhl_mac import bhl_pkg::*; #(
   parameter int OPND_W = 12
) (
   input  logic              clock,
   input  mac_ctl_type       ctl,
   input  logic [SRC_W-1:0]  load_val,
   input  logic [OPND_W-1:0] opnd_b,
   input  logic [OPND_W-1:0] addend,
   output logic [SRC_W-1:0]  acc
);

   localparam int LO_W = HALF_W;
   localparam int HI_W = SRC_W - HALF_W;

   logic [SRC_W-1:0]       acc_ff, acc_in;
   logic [LO_W+OPND_W-1:0] plo_ff, plo_in;
   logic [HI_W+OPND_W-1:0] phi_ff, phi_in;
   logic [OPND_W-1:0]      add_ff, add_in;

   always_comb begin
      acc_in = acc_ff;
      plo_in = plo_ff;
      phi_in = phi_ff;
      add_in = add_ff;
      if (ctl.load) begin
         acc_in = load_val;
      end
      // partial products of the accumulator halves
      if (ctl.mul) begin
         plo_in = acc_ff[LO_W-1:0] * opnd_b;
         phi_in = acc_ff[SRC_W-1:LO_W] * opnd_b;
         add_in = addend;
      end
      // recombine; bits above SRC_W drop out
      if (ctl.add) begin
         acc_in = SRC_W'(plo_ff) + (SRC_W'(phi_ff) << LO_W) + SRC_W'(add_ff);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      plo_ff <= plo_in;
      phi_ff <= phi_in;
      add_ff <= add_in;
   end

   assign acc = acc_ff;

endmodule

// ----- rtl/core/bhl_back.sv -----
// Back end: configuration registers, element counters, offset sequencer and
// response register. Depends on bhl_pkg, bhl_ifs, bhl_div and bhl_mac.
module bhl_back import bhl_pkg::*; #(
   parameter int DIM_BITS = DEF_DIM_BITS,
   parameter int MAX_CUBE = DEF_MAX_CUBE
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output logic       cmd_pop,
   bhl_rsp_if.source  rsp_ch,
   bhl_csr_if.sink    csr_ch
);

   localparam int CUBE_BITS = $clog2(MAX_CUBE + 1);
   localparam int SQ_W      = 2 * CUBE_BITS;
   localparam int OPND_W    = (DIM_BITS > SQ_W) ? DIM_BITS : SQ_W;

   // Configuration
   logic [DIM_BITS-1:0]   dim_h_ff, dim_h_in, dim_w_ff, dim_w_in;
   logic [DIM_BITS-1:0]   dim_c_ff, dim_c_in, dim_n_ff, dim_n_in;
   logic [CUBE_REG_W-1:0] cube_ff, cube_in;
   logic [ELEM_W-1:0]     elem_ff, elem_in;

   // Counters and sequencer
   logic [DIM_BITS-1:0]   h_ff, h_in, w_ff, w_in, c_ff, c_in, n_ff, n_in;
   seq_state_type         state_ff, state_in;
   step_type              step_ff, step_in;
   logic [SQ_W-1:0]       k2_ff, k2_in, c0k_ff, c0k_in;

   // Response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SRC_W-1:0]      rsp_src_ff, rsp_src_in;
   logic [DST_W-1:0]      rsp_dst_ff, rsp_dst_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Effective sizes
   logic [DIM_BITS-1:0]   dh, dw, dc, dn;
   logic [CUBE_BITS-1:0]  k_eff;
   logic [DIM_BITS:0]     h_inc, w_inc, c_inc, n_inc;
   logic                  h_end, w_end, c_end, n_end, last_now;
   logic                  out_free, is_restart;

   // Divider and lanes
   logic                  div_start, div_busy;
   logic [DIM_BITS-1:0]   div_dividend, div_quo;
   logic [CUBE_BITS-1:0]  div_rem;
   mac_ctl_type           src_ctl, dst_ctl;
   logic [OPND_W-1:0]     src_b, src_add, dst_b, dst_add;
   logic [SRC_W-1:0]      src_acc, dst_acc;

   // Register writes; unknown indexes are dropped
   assign csr_ch.ready = 1'b1;

   always_comb begin
      dim_h_in = dim_h_ff;
      dim_w_in = dim_w_ff;
      dim_c_in = dim_c_ff;
      dim_n_in = dim_n_ff;
      cube_in  = cube_ff;
      elem_in  = elem_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_DIM_H:      dim_h_in = csr_ch.wdata[DIM_BITS-1:0];
            CSR_DIM_W:      dim_w_in = csr_ch.wdata[DIM_BITS-1:0];
            CSR_DIM_C:      dim_c_in = csr_ch.wdata[DIM_BITS-1:0];
            CSR_DIM_N:      dim_n_in = csr_ch.wdata[DIM_BITS-1:0];
            CSR_BLK_SIZE:   cube_in  = csr_ch.wdata[CUBE_REG_W-1:0];
            CSR_ELEM_BYTES: elem_in  = csr_ch.wdata[ELEM_W-1:0];
            default: ;
         endcase
      end
   end

   // Zero dimension acts as one; cube clamped to 1..MAX_CUBE
   assign dh = (dim_h_ff == '0) ? DIM_BITS'(1) : dim_h_ff;
   assign dw = (dim_w_ff == '0) ? DIM_BITS'(1) : dim_w_ff;
   assign dc = (dim_c_ff == '0) ? DIM_BITS'(1) : dim_c_ff;
   assign dn = (dim_n_ff == '0) ? DIM_BITS'(1) : dim_n_ff;

   always_comb begin
      if (cube_ff == '0) begin
         k_eff = CUBE_BITS'(1);
      end else if (int'(cube_ff) > MAX_CUBE) begin
         k_eff = CUBE_BITS'(MAX_CUBE);
      end else begin
         k_eff = CUBE_BITS'(cube_ff);
      end
   end

   // Counter end detection; a counter past its size counts as at its end
   assign h_inc    = {1'b0, h_ff} + (DIM_BITS+1)'(1);
   assign w_inc    = {1'b0, w_ff} + (DIM_BITS+1)'(1);
   assign c_inc    = {1'b0, c_ff} + (DIM_BITS+1)'(1);
   assign n_inc    = {1'b0, n_ff} + (DIM_BITS+1)'(1);
   assign h_end    = (h_inc >= {1'b0, dh});
   assign w_end    = (w_inc >= {1'b0, dw});
   assign c_end    = (c_inc >= {1'b0, dc});
   assign n_end    = (n_inc >= {1'b0, dn});
   assign last_now = h_end && w_end && c_end && n_end;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign is_restart   = (cmd.kind == CMD_RESTART);
   assign div_dividend = is_restart ? '0 : c_ff;

   // Horner operands per step:
   //   src = ((((c1*H + h)*W + w)*N + n)*k^2 + c0*(k+1)) * bytes
   //   dst = (((h*W + w)*C + c)*N + n) * bytes
   always_comb begin
      case (step_ff)
         STEP_H: begin
            src_b = OPND_W'(dh);     src_add = OPND_W'(h_ff);
            dst_b = OPND_W'(dw);     dst_add = OPND_W'(w_ff);
         end
         STEP_W: begin
            src_b = OPND_W'(dw);     src_add = OPND_W'(w_ff);
            dst_b = OPND_W'(dc);     dst_add = OPND_W'(c_ff);
         end
         STEP_N: begin
            src_b = OPND_W'(dn);     src_add = OPND_W'(n_ff);
            dst_b = OPND_W'(dn);     dst_add = OPND_W'(n_ff);
         end
         STEP_CUBE: begin
            src_b = OPND_W'(k2_ff);  src_add = OPND_W'(c0k_ff);
            dst_b = OPND_W'(elem_ff); dst_add = '0;
         end
         STEP_SCALE: begin
            src_b = OPND_W'(elem_ff); src_add = '0;
            dst_b = OPND_W'(1);      dst_add = '0;
         end
         default: begin
            src_b = '0;              src_add = '0;
            dst_b = '0;              dst_add = '0;
         end
      endcase
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      h_in         = h_ff;
      w_in         = w_ff;
      c_in         = c_ff;
      n_in         = n_ff;
      k2_in        = k2_ff;
      c0k_in       = c0k_ff;
      cmd_pop      = 1'b0;
      div_start    = 1'b0;
      src_ctl      = '0;
      dst_ctl      = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_src_in   = rsp_src_ff;
      rsp_dst_in   = rsp_dst_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.valid) begin
               cmd_pop   = 1'b1;
               div_start = 1'b1;
               if (is_restart) begin
                  h_in = '0;
                  w_in = '0;
                  c_in = '0;
                  n_in = '0;
               end
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!div_busy) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            k2_in        = SQ_W'(k_eff) * SQ_W'(k_eff);
            c0k_in       = SQ_W'(div_rem) * SQ_W'(k_eff) + SQ_W'(div_rem);
            src_ctl.load = 1'b1;
            dst_ctl.load = 1'b1;
            step_in      = STEP_H;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            src_ctl.mul = 1'b1;
            dst_ctl.mul = 1'b1;
            state_in    = ST_ADD;
         end
         ST_ADD: begin
            src_ctl.add = 1'b1;
            dst_ctl.add = 1'b1;
            if (step_ff == STEP_SCALE) begin
               state_in = ST_DONE;
            end else begin
               step_in  = step_type'(step_ff + 3'd1);
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_src_in   = src_acc;
               rsp_dst_in   = dst_acc[DST_W-1:0];
               rsp_last_in  = last_now;
               // odometer advance, n fastest
               if (n_end) begin
                  n_in = '0;
                  if (c_end) begin
                     c_in = '0;
                     if (w_end) begin
                        w_in = '0;
                        h_in = h_end ? '0 : h_inc[DIM_BITS-1:0];
                     end else begin
                        w_in = w_inc[DIM_BITS-1:0];
                     end
                  end else begin
                     c_in = c_inc[DIM_BITS-1:0];
                  end
               end else begin
                  n_in = n_inc[DIM_BITS-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_h_ff     <= DIM_BITS'(1);
         dim_w_ff     <= DIM_BITS'(1);
         dim_c_ff     <= DIM_BITS'(1);
         dim_n_ff     <= DIM_BITS'(1);
         cube_ff      <= CUBE_RESET;
         elem_ff      <= ELEM_RESET;
         h_ff         <= '0;
         w_ff         <= '0;
         c_ff         <= '0;
         n_ff         <= '0;
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_H;
         rsp_valid_ff <= 1'b0;
      end else begin
         dim_h_ff     <= dim_h_in;
         dim_w_ff     <= dim_w_in;
         dim_c_ff     <= dim_c_in;
         dim_n_ff     <= dim_n_in;
         cube_ff      <= cube_in;
         elem_ff      <= elem_in;
         h_ff         <= h_in;
         w_ff         <= w_in;
         c_ff         <= c_in;
         n_ff         <= n_in;
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers, no reset
   always_ff @(posedge clock) begin
      k2_ff       <= k2_in;
      c0k_ff      <= c0k_in;
      rsp_src_ff  <= rsp_src_in;
      rsp_dst_ff  <= rsp_dst_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.src_byte_offset = rsp_src_ff;
   assign rsp_ch.dst_byte_offset = rsp_dst_ff;
   assign rsp_ch.last            = rsp_last_ff;

   // c = c1 * k + c0
   bhl_div #(
      .DIM_BITS  (DIM_BITS),
      .CUBE_BITS (CUBE_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (k_eff),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   bhl_mac #(
      .OPND_W   (OPND_W)
   ) u_src_mac (
      .clock    (clock),
      .ctl      (src_ctl),
      .load_val (SRC_W'(div_quo)),
      .opnd_b   (src_b),
      .addend   (src_add),
      .acc      (src_acc)
   );

   bhl_mac #(
      .OPND_W   (OPND_W)
   ) u_dst_mac (
      .clock    (clock),
      .ctl      (dst_ctl),
      .load_val (SRC_W'(h_ff)),
      .opnd_b   (dst_b),
      .addend   (dst_add),
      .acc      (dst_acc)
   );

   // Checks
   a_div_in_state: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> (state_ff == ST_DIV))
      else $error("divider running outside its state");

   a_div_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PREP) |->
         ((32'(div_quo) * 32'(k_eff) + 32'(div_rem) == 32'(c_ff)) && (div_rem < k_eff)))
      else $error("channel split does not match counter");

   a_wrap_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free && last_now) |=>
         (h_ff == '0 && w_ff == '0 && c_ff == '0 && n_ff == '0))
      else $error("counters did not wrap after final element");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside completion");

endmodule

// ----- rtl/core/blocked_to_hwcn_layout_address_gen.sv -----
// Top level of the blocked-to-HWCN layout address generator.
// Depends on bhl_pkg, bhl_ifs, bhl_front and bhl_back.
//
// Usage:
//  - req_ch carries one bit, restart. Each transaction asks for the next element
//    of the H,W,C,N walk (n fastest); restart=1 starts over at the first element.
//  - rsp_ch returns one transaction per request: source byte offset into the
//    blocked C1,H,W,N,Co,C0 tensor (diagonal of each cube only), destination
//    byte offset into the HWCN tensor, and last on the final element, after
//    which the walk wraps to the start.
//  - csr_ch writes the registers dim_h, dim_w, dim_c, dim_n, blk_size and
//    elem_bytes at indexes 0 to 5; other indexes are dropped. Write only while
//    no request is outstanding. csr_ch.ready is always high.
//  - Each request passes through the bit-serial channel divider, a prepare state
//    and five multiply-add steps of the offset lanes (a multiply state and an add
//    state each) before its response is registered; the back end works on one
//    request at a time and takes the next after loading that response.
//  - A two-entry queue takes requests while the back end works; a stalled
//    response holds in its register and the back end waits on it.
//  - Synchronous reset empties the queue, zeroes the counters and loads the
//    register defaults (all dims 1, blk_size 16, elem_bytes 2).
module blocked_to_hwcn_layout_address_gen import bhl_pkg::*; #(
   parameter int DIM_BITS = DEF_DIM_BITS,
   parameter int MAX_CUBE = DEF_MAX_CUBE
) (
   input  logic       clock,
   input  logic       reset,
   bhl_req_if.sink    req_ch,
   bhl_rsp_if.source  rsp_ch,
   bhl_csr_if.sink    csr_ch
);

   cmd_type cmd;
   logic    cmd_pop;

   // Request intake and queue
   bhl_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .cmd     (cmd),
      .cmd_pop (cmd_pop)
   );

   // Offset computation and response
   bhl_back #(
      .DIM_BITS (DIM_BITS),
      .MAX_CUBE (MAX_CUBE)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .cmd_pop (cmd_pop),
      .rsp_ch  (rsp_ch),
      .csr_ch  (csr_ch)
   );

endmodule

// ----- dv/tb_blocked_to_hwcn_layout_address_gen.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the blocked-to-HWCN layout address generator.
// Needs bhl_pkg, the bhl_ifs channel interfaces and the block's RTL; nothing else.
module tb_blocked_to_hwcn_layout_address_gen;
   import bhl_pkg::*;

   localparam int DIM_W          = DEF_DIM_BITS;
   localparam int MAX_CUBE       = DEF_MAX_CUBE;
   localparam int ITEM_TARGET    = 950;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 64;
   localparam int LONG_HOLD      = 300;

   // Register indexes outside the map; writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [SRC_W-1:0] src;
      logic [DST_W-1:0] dst;
      logic             last;
   } element_type;

   logic clock = 1'b0;
   logic reset;

   bhl_req_if req_ch ();
   bhl_rsp_if rsp_ch ();
   bhl_csr_if csr_ch ();

   blocked_to_hwcn_layout_address_gen #(
      .DIM_BITS (DIM_W),
      .MAX_CUBE (MAX_CUBE)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor copy of the registers and the walk counters
   logic [DIM_W-1:0]      cfg_dim_h, cfg_dim_w, cfg_dim_c, cfg_dim_n;
   logic [CUBE_REG_W-1:0] cfg_cube;
   logic [ELEM_W-1:0]     cfg_elem;
   logic [DIM_W-1:0]      h_pos, w_pos, c_pos, n_pos;

   element_type pending_elements[$];
   int unsigned errors = 0;
   int unsigned items_sent = 0;
   int unsigned idle_cycles = 0;

   // Sender burst control and receiver hold request
   int unsigned burst_left = 0;
   int unsigned sender_gap_max = 0;
   int unsigned rsp_hold_len = 0;
   int unsigned hold_count = 0;
   int unsigned pattern_age = 0;
   logic [15:0] ready_pattern = 16'hFFFF;

   function automatic longint unsigned dim_or_one(input logic [DIM_W-1:0] d);
      return (d == '0) ? 64'd1 : 64'(d);
   endfunction

   task automatic reset_model();
      cfg_dim_h = 1;
      cfg_dim_w = 1;
      cfg_dim_c = 1;
      cfg_dim_n = 1;
      cfg_cube  = CUBE_RESET;
      cfg_elem  = ELEM_RESET;
      h_pos = '0;
      w_pos = '0;
      c_pos = '0;
      n_pos = '0;
   endtask

   // Offsets of the current element, then step the walk (n fastest)
   task automatic predict_element(input logic restart);
      longint unsigned dh, dw, dc, dn, k, cube_sq, ncc, wncc, hwncc;
      longint unsigned hp, wp, cp, np, src, dst;
      element_type elem;
      dh = dim_or_one(cfg_dim_h);
      dw = dim_or_one(cfg_dim_w);
      dc = dim_or_one(cfg_dim_c);
      dn = dim_or_one(cfg_dim_n);
      k  = (cfg_cube == '0) ? 64'd1 :
           (cfg_cube > MAX_CUBE) ? 64'(MAX_CUBE) : 64'(cfg_cube);
      if (restart) begin
         h_pos = '0;
         w_pos = '0;
         c_pos = '0;
         n_pos = '0;
      end
      hp = 64'(h_pos);
      wp = 64'(w_pos);
      cp = 64'(c_pos);
      np = 64'(n_pos);
      cube_sq = k * k;
      ncc     = dn * cube_sq;
      wncc    = dw * ncc;
      hwncc   = dh * wncc;
      // only the cube diagonal is read: co equals c0
      src = (cp / k) * hwncc + hp * wncc + wp * ncc + np * cube_sq + (cp % k) * (k + 1);
      dst = ((hp * dw + wp) * dc + cp) * dn + np;
      src = src * 64'(cfg_elem);
      dst = dst * 64'(cfg_elem);
      elem.src  = src[SRC_W-1:0];
      elem.dst  = dst[DST_W-1:0];
      elem.last = (hp + 1 >= dh) && (wp + 1 >= dw) && (cp + 1 >= dc) && (np + 1 >= dn);
      pending_elements.push_back(elem);
      // a counter at or past its dimension wraps on its next advance
      if (np + 1 < dn) n_pos = n_pos + 1;
      else begin
         n_pos = '0;
         if (cp + 1 < dc) c_pos = c_pos + 1;
         else begin
            c_pos = '0;
            if (wp + 1 < dw) w_pos = w_pos + 1;
            else begin
               w_pos = '0;
               if (hp + 1 < dh) h_pos = h_pos + 1;
               else h_pos = '0;
            end
         end
      end
   endtask

   // One request transaction, with random gaps between bursts
   task automatic send_request(input logic restart);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = $urandom_range(0, sender_gap_max);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid   <= 1'b1;
      req_ch.restart <= restart;
      do @(posedge clock); while (!req_ch.ready);
      predict_element(restart);
      items_sent++;
   endtask

   // Stop offering and wait until every response is back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_elements.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= data;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_DIM_H:      cfg_dim_h = data[DIM_W-1:0];
         CSR_DIM_W:      cfg_dim_w = data[DIM_W-1:0];
         CSR_DIM_C:      cfg_dim_c = data[DIM_W-1:0];
         CSR_DIM_N:      cfg_dim_n = data[DIM_W-1:0];
         CSR_BLK_SIZE:   cfg_cube  = data[CUBE_REG_W-1:0];
         CSR_ELEM_BYTES: cfg_elem  = data[ELEM_W-1:0];
         default: ;
      endcase
   endtask

   // Rewrite all six registers once the block is idle
   task automatic set_shape(input logic [CSR_DATA_W-1:0] h, w, c, n, cube, elem_sz);
      wait_drained();
      write_csr(CSR_DIM_H, h);
      write_csr(CSR_DIM_W, w);
      write_csr(CSR_DIM_C, c);
      write_csr(CSR_DIM_N, n);
      write_csr(CSR_BLK_SIZE, cube);
      write_csr(CSR_ELEM_BYTES, elem_sz);
      csr_ch.valid <= 1'b0;
   endtask

   // Random register values, sometimes with junk above the field
   function automatic logic [CSR_DATA_W-1:0] rand_dim();
      logic [DIM_W-1:0] d;
      case ($urandom_range(0, 9))
         0:       d = '0;
         1:       d = ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'($urandom_range(41, 4095));
         2:       d = 12'($urandom_range(6, 40));
         default: d = 12'($urandom_range(1, 5));
      endcase
      return {4'($urandom_range(0, 1) != 0 ? $urandom : 0), d};
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_cube();
      logic [CUBE_REG_W-1:0] k;
      case ($urandom_range(0, 5))
         0:       k = '0;
         1:       k = 6'($urandom_range(MAX_CUBE + 1, 63));
         2:       k = 6'(MAX_CUBE);
         default: k = 6'($urandom_range(1, 16));
      endcase
      return {10'($urandom_range(0, 1) != 0 ? $urandom : 0), k};
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_elem();
      return {13'($urandom_range(0, 1) != 0 ? $urandom : 0), 3'($urandom_range(0, 7))};
   endfunction

   task automatic randomize_setting();
      int unsigned picks;
      if ($urandom_range(0, 3) != 0)
         set_shape(rand_dim(), rand_dim(), rand_dim(), rand_dim(), rand_cube(), rand_elem());
      else begin
         // a few single writes, spare indexes included
         wait_drained();
         picks = $urandom_range(1, 3);
         repeat (picks) write_csr(CSR_IDX_W'($urandom_range(0, 7)), rand_dim());
         csr_ch.valid <= 1'b0;
      end
   endtask

   // ---------------------------------------------------------------- tests

   // Register defaults after reset: a 1x1x1x1 tensor, every element is last
   task automatic test_reset_defaults();
      sender_gap_max = 3;
      send_request(1'b0);
      send_request(1'b1);
      send_request(1'b0);
   endtask

   // Zero dims and cube act as one, oversized cube clamps, element sizes 0, 7 and 5
   task automatic test_register_extremes();
      set_shape(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_request(1'b1);
      send_request(1'b0);
      set_shape(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request(1'b0);
      send_request(1'b0);
      // spare indexes are dropped; cube just above the limit
      wait_drained();
      write_csr(CSR_SPARE_6, 16'hFFFF);
      write_csr(CSR_SPARE_7, 16'h0000);
      write_csr(CSR_BLK_SIZE, 16'(MAX_CUBE + 1));
      write_csr(CSR_ELEM_BYTES, 16'd5);
      csr_ch.valid <= 1'b0;
      send_request(1'b0);
   endtask

   // Full walk of a small tensor, last flag, wrap and a mid-walk restart
   task automatic test_walk_and_restart();
      set_shape(16'd2, 16'd2, 16'd1, 16'd1, 16'd4, 16'd1);
      repeat (5) send_request(1'b0);
      send_request(1'b1);
      send_request(1'b0);
   endtask

   // Shrink dims under running counters so they sit past their ends
   task automatic test_counter_past_dim();
      set_shape(16'd1, 16'd1, 16'd3, 16'd4, 16'd2, 16'd1);
      send_request(1'b1);
      repeat (5) send_request(1'b0);
      wait_drained();
      write_csr(CSR_DIM_N, 16'd2);
      write_csr(CSR_DIM_C, 16'd1);
      csr_ch.valid <= 1'b0;
      repeat (3) send_request(1'b0);
   endtask

   // Walk h and c up, then open all dims to the maximum for wide offsets
   task automatic test_large_offsets();
      set_shape(16'd4095, 16'd1, 16'd1, 16'd1, 16'd16, 16'd2);
      send_request(1'b1);
      repeat (3) send_request(1'b0);
      set_shape(16'd4095, 16'd1, 16'd4095, 16'd1, 16'd1, 16'd2);
      repeat (4) send_request(1'b0);
      set_shape(16'd4095, 16'd4095, 16'd4095, 16'd4095, 16'd2, 16'd7);
      repeat (2) send_request(1'b0);
   endtask

   // Receiver holds off while requests keep coming, so the input stalls
   task automatic test_backpressure();
      set_shape(16'd3, 16'd2, 16'd5, 16'd3, 16'd4, 16'd2);
      sender_gap_max = 0;
      rsp_hold_len = LONG_HOLD;
      repeat (12) send_request(1'b0);
      wait_drained();
   endtask

   // Random settings and walks, mostly small shapes so wraps come often
   task automatic test_random_walks();
      int unsigned batch;
      while (items_sent < ITEM_TARGET) begin
         randomize_setting();
         sender_gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
         batch = $urandom_range(5, 50);
         for (int i = 0; i < batch; i++)
            send_request(($urandom_range(0, 19) == 0) || (i == 0 && $urandom_range(0, 3) == 0));
      end
   endtask

   task automatic finish_run();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   endtask

   // Main sequence
   initial begin
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.restart <= 1'b0;
      csr_ch.valid   <= 1'b0;
      csr_ch.index   <= CSR_DIM_H;
      csr_ch.wdata   <= '0;
      reset_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_register_extremes();
      test_walk_and_restart();
      test_counter_past_dim();
      test_large_offsets();
      test_backpressure();
      test_random_walks();
      finish_run();
   end

   // Response side: a rotating stall pattern, reshuffled whenever pattern_age wraps to zero
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_len != 0) begin
            hold_count = rsp_hold_len;
            rsp_hold_len = 0;
         end
         if (hold_count != 0) begin
            hold_count--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (pattern_age == 0) begin
               case ($urandom_range(0, 3))
                  0:       ready_pattern = 16'hFFFF;
                  1:       ready_pattern = 16'($urandom & $urandom);
                  default: ready_pattern = 16'($urandom);
               endcase
            end
            pattern_age = (pattern_age + 1) % 64;
            rsp_ch.ready  <= ready_pattern[0];
            ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
         end
      end
   end

   // Compare each response transaction with the oldest prediction
   always @(posedge clock) begin
      element_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_elements.size() == 0) begin
            $display("%0t: response with none expected: src=%h dst=%h last=%b", $time,
                     rsp_ch.src_byte_offset, rsp_ch.dst_byte_offset, rsp_ch.last);
            errors++;
         end else begin
            want = pending_elements.pop_front();
            if (rsp_ch.src_byte_offset !== want.src) begin
               $display("%0t: src_byte_offset expected %h actual %h", $time, want.src,
                        rsp_ch.src_byte_offset);
               errors++;
            end
            if (rsp_ch.dst_byte_offset !== want.dst) begin
               $display("%0t: dst_byte_offset expected %h actual %h", $time, want.dst,
                        rsp_ch.dst_byte_offset);
               errors++;
            end
            if (rsp_ch.last !== want.last) begin
               $display("%0t: last expected %b actual %b", $time, want.last, rsp_ch.last);
               errors++;
            end
         end
      end
   end

   // Watchdog: too long without any transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d responses outstanding", $time,
                  idle_cycles, pending_elements.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

endmodule

// ----- blocked_to_hwcn_layout_address_gen.f -----
rtl/core/bhl_pkg.sv
rtl/core/bhl_ifs.sv
rtl/core/bhl_front.sv
rtl/core/bhl_div.sv
rtl/core/bhl_mac.sv
rtl/core/bhl_back.sv
rtl/core/blocked_to_hwcn_layout_address_gen.sv
dv/tb_blocked_to_hwcn_layout_address_gen.sv
